// File: rtl/psf_pkg.sv
// Shared types, constants and small lane functions for the pixel span fill block.
// No dependencies. Used by every module of the block under rtl/.
package psf_pkg;

    // Widths and limits of the span datapath, sized for the largest span limit.
    localparam int SPAN_LIMIT = 48;
    localparam int COUNT_W    = 6;
    localparam int BYTES_W    = 8;
    localparam int WORDS_W    = 6;
    localparam int ADDR_W     = 32;
    localparam int WADDR_W    = 30;
    localparam int DATA_W     = 32;
    localparam int LANES      = 4;

    // Pixel depth register codes.
    typedef enum logic [1:0] {
        DEPTH_8BPP  = 2'd0,
        DEPTH_16BPP = 2'd1,
        DEPTH_24BPP = 2'd2,
        DEPTH_32BPP = 2'd3
    } t_depth;

    localparam t_depth DEPTH_RESET = DEPTH_32BPP;

    // Back end sequencer states.
    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } t_back_state;

    // One classified span waiting for the back end.
    typedef struct packed {
        logic [WADDR_W-1:0] word_base;
        logic [1:0]         lead;
        logic [1:0]         end_lane;
        logic [WORDS_W-1:0] nwords_m1;
        t_depth             depth;
        logic [DATA_W-1:0]  color;
    } t_span_cmd;

    // Color byte index for lane 0 of the first word: (-lead) mod bytes per pixel.
    function automatic logic [1:0] init_phase(input logic [1:0] lead, input t_depth depth);
        logic [1:0] ph;
        begin
            unique case (depth)
                DEPTH_8BPP:  ph = 2'd0;
                DEPTH_16BPP: ph = {1'b0, lead[0]};
                DEPTH_24BPP: begin
                    unique case (lead)
                        2'd1:    ph = 2'd2;
                        2'd2:    ph = 2'd1;
                        default: ph = 2'd0;
                    endcase
                end
                DEPTH_32BPP: ph = 2'd0 - lead;
                default:     ph = 2'd0;
            endcase
            return ph;
        end
    endfunction

    // Reduce a small byte position (at most 5) modulo the bytes per pixel.
    function automatic logic [1:0] color_index(input logic [2:0] v, input t_depth depth);
        logic [2:0] r;
        begin
            unique case (depth)
                DEPTH_8BPP:  r = 3'd0;
                DEPTH_16BPP: r = {2'b00, v[0]};
                DEPTH_24BPP: r = (v >= 3'd3) ? v - 3'd3 : v;
                DEPTH_32BPP: r = {1'b0, v[1:0]};
                default:     r = 3'd0;
            endcase
            return r[1:0];
        end
    endfunction

    // Lanes at or above the lead offset.
    function automatic logic [LANES-1:0] mask_from(input logic [1:0] lead);
        return 4'b1111 << lead;
    endfunction

    // Lanes below the end lane; an end lane of zero means the word is full.
    function automatic logic [LANES-1:0] mask_below(input logic [1:0] end_lane);
        return (end_lane == 2'd0) ? 4'b1111 : ~(4'b1111 << end_lane);
    endfunction

endpackage

// File: rtl/psf_queue.sv
// Two-entry command queue between the span classifier and the word emitter.
// Depends on psf_pkg for the span command type.
module psf_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  psf_pkg::t_span_cmd i_cmd,
    input  logic               i_pop,
    output psf_pkg::t_span_cmd o_cmd,
    output logic               o_valid,
    output logic               o_full
);

    logic [1:0]         r_count;
    logic [1:0]         n_count;
    psf_pkg::t_span_cmd r_head;
    psf_pkg::t_span_cmd r_tail;

    // Occupancy follows pushes and pops.
    always_comb begin
        n_count = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    // The head entry is always the oldest; the tail holds the second one.
    always_ff @(posedge i_clk) begin
        unique case ({i_push, i_pop})
            2'b10: begin
                if (r_count == 2'd0) begin
                    r_head <= i_cmd;
                end else begin
                    r_tail <= i_cmd;
                end
            end
            2'b01: begin
                r_head <= r_tail;
            end
            2'b11: begin
                if (r_count == 2'd1) begin
                    r_head <= i_cmd;
                end else begin
                    r_head <= r_tail;
                    r_tail <= i_cmd;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_cmd   = r_head;
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);

    // A pop only ever takes an entry that is present.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != 2'd0))
        else $error("queue popped while empty");

    // Occupancy never exceeds two entries.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue occupancy out of range");

    // A push into a full queue needs a pop in the same cycle.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && r_count == 2'd2) |-> i_pop)
        else $error("queue overflow");

endmodule

// File: rtl/psf_front.sv
// Span classifier: holds the pixel depth register, accepts requests and turns
// each one into a span command for the queue. Depends on psf_pkg.
module psf_front #(
    parameter int MAX_SPAN = psf_pkg::SPAN_LIMIT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_wdata,
    input  logic                          i_start,
    input  logic                          i_queue_full,
    input  logic [psf_pkg::ADDR_W-1:0]    i_start_address,
    input  logic [psf_pkg::COUNT_W-1:0]   i_pixel_count,
    input  logic [psf_pkg::DATA_W-1:0]    i_fill_color,
    output logic                          o_busy,
    output logic                          o_push,
    output psf_pkg::t_span_cmd            o_cmd
);

    localparam logic [psf_pkg::COUNT_W-1:0] SPAN_CAP = psf_pkg::COUNT_W'(MAX_SPAN);

    psf_pkg::t_depth                r_depth;
    logic [psf_pkg::COUNT_W-1:0]    count_sat;
    logic [psf_pkg::ADDR_W-1:0]     addr_al;
    logic [psf_pkg::BYTES_W-1:0]    bytes_pp;
    logic [psf_pkg::BYTES_W-1:0]    nbytes;
    logic [psf_pkg::BYTES_W-1:0]    span_end;
    logic [psf_pkg::BYTES_W-1:0]    nwords;

    // Pixel depth register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= psf_pkg::DEPTH_RESET;
        end else if (i_cfg_we) begin
            r_depth <= psf_pkg::t_depth'(i_cfg_wdata);
        end
    end

    // Saturate the count, align the start for 16 and 32 bpp and size the span in bytes and words.
    always_comb begin
        count_sat = (i_pixel_count > SPAN_CAP) ? SPAN_CAP : i_pixel_count;
        addr_al   = i_start_address;
        unique case (r_depth)
            psf_pkg::DEPTH_16BPP: addr_al[0]   = 1'b0;
            psf_pkg::DEPTH_32BPP: addr_al[1:0] = 2'b00;
            default: begin
            end
        endcase
        bytes_pp = psf_pkg::BYTES_W'(r_depth) + 8'd1;
        nbytes   = psf_pkg::BYTES_W'(count_sat) * bytes_pp;
        span_end = nbytes + psf_pkg::BYTES_W'(addr_al[1:0]);
        nwords   = (span_end + 8'd3) >> 2;
    end

    // Build the queued command; a zero count is consumed without a push.
    always_comb begin
        o_cmd.word_base = addr_al[psf_pkg::ADDR_W-1:2];
        o_cmd.lead      = addr_al[1:0];
        o_cmd.end_lane  = span_end[1:0];
        o_cmd.nwords_m1 = psf_pkg::WORDS_W'(nwords - 8'd1);
        o_cmd.depth     = r_depth;
        o_cmd.color     = i_fill_color;
    end

    assign o_busy = i_queue_full;
    assign o_push = i_start && !i_queue_full && (count_sat != '0);

endmodule

// File: rtl/psf_back.sv
// Word emitter: walks one span command a word per cycle and drives the
// registered write transaction outputs. Depends on psf_pkg.
module psf_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  psf_pkg::t_span_cmd            i_cmd,
    output logic                          o_pop,
    output logic                          o_write_strobe,
    output logic [psf_pkg::WADDR_W-1:0]   o_word_address,
    output logic [psf_pkg::DATA_W-1:0]    o_write_data,
    output logic [psf_pkg::LANES-1:0]     o_byte_enable,
    output logic                          o_last_write
);

    psf_pkg::t_back_state           r_state;
    psf_pkg::t_back_state           n_state;
    psf_pkg::t_span_cmd             r_cmd;
    logic [psf_pkg::WORDS_W-1:0]    r_word_idx;
    logic [1:0]                     r_phase;

    logic                           is_last;
    logic                           load;
    logic                           emit;
    logic [psf_pkg::WADDR_W-1:0]    word_addr;
    logic [psf_pkg::DATA_W-1:0]     word_data;
    logic [psf_pkg::LANES-1:0]      word_be;
    logic [1:0]                     lane_idx;
    logic [1:0]                     n_phase;

    logic                           r_strobe;
    logic [psf_pkg::WADDR_W-1:0]    r_word_address;
    logic [psf_pkg::DATA_W-1:0]     r_write_data;
    logic [psf_pkg::LANES-1:0]      r_byte_enable;
    logic                           r_last_write;

    assign is_last = (r_word_idx == r_cmd.nwords_m1);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            psf_pkg::BK_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = psf_pkg::BK_RUN;
                end
            end
            psf_pkg::BK_RUN: begin
                if (is_last && !i_cmd_valid) begin
                    n_state = psf_pkg::BK_IDLE;
                end
            end
            default: n_state = psf_pkg::BK_IDLE;
        endcase
    end

    // State outputs: when to take a command and when a word goes out.
    always_comb begin
        load = 1'b0;
        emit = 1'b0;
        unique case (r_state)
            psf_pkg::BK_IDLE: load = i_cmd_valid;
            psf_pkg::BK_RUN: begin
                emit = 1'b1;
                load = is_last && i_cmd_valid;
            end
            default: begin
            end
        endcase
    end

    assign o_pop = load;

    // Data and byte enables of the current word, one color byte per lane.
    always_comb begin
        word_addr = r_cmd.word_base + psf_pkg::WADDR_W'(r_word_idx);
        word_be   = 4'b1111;
        if (r_word_idx == '0) begin
            word_be = word_be & psf_pkg::mask_from(r_cmd.lead);
        end
        if (is_last) begin
            word_be = word_be & psf_pkg::mask_below(r_cmd.end_lane);
        end
        word_data = '0;
        lane_idx  = 2'd0;
        for (int lane = 0; lane < psf_pkg::LANES; lane++) begin
            lane_idx = psf_pkg::color_index({1'b0, r_phase} + 3'(lane), r_cmd.depth);
            if (word_be[lane]) begin
                word_data[8*lane +: 8] = r_cmd.color[8*lane_idx +: 8];
            end
        end
        // Four bytes on, the phase only moves at three bytes per pixel.
        if (r_cmd.depth == psf_pkg::DEPTH_24BPP) begin
            n_phase = (r_phase == 2'd2) ? 2'd0 : r_phase + 2'd1;
        end else begin
            n_phase = r_phase;
        end
    end

    // Sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= psf_pkg::BK_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= emit;
        end
    end

    // Working span and word walk.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd      <= i_cmd;
            r_word_idx <= '0;
            r_phase    <= psf_pkg::init_phase(i_cmd.lead, i_cmd.depth);
        end else if (emit) begin
            r_word_idx <= r_word_idx + psf_pkg::WORDS_W'(1);
            r_phase    <= n_phase;
        end
    end

    // Output transaction register.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_word_address <= word_addr;
            r_write_data   <= word_data;
            r_byte_enable  <= word_be;
            r_last_write   <= is_last;
        end
    end

    assign o_write_strobe = r_strobe;
    assign o_word_address = r_word_address;
    assign o_write_data   = r_write_data;
    assign o_byte_enable  = r_byte_enable;
    assign o_last_write   = r_last_write;

    // The word walk never passes the last word of the span.
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psf_pkg::BK_RUN) |-> (r_word_idx <= r_cmd.nwords_m1))
        else $error("word index past end of span");

    // Every emitted word writes at least one byte.
    a_be_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (r_byte_enable != '0))
        else $error("write transaction without byte enables");

    // The sequencer goes idle only after the last word of a span.
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == psf_pkg::BK_RUN && r_state == psf_pkg::BK_IDLE)
            |-> (r_strobe && r_last_write))
        else $error("span ended without a last write");

endmodule

// File: rtl/pixel_span_fill.sv
// Solid span fill: a span request becomes aligned 32-bit word writes with byte enables.
// A request taken while the emitter is idle passes the queue and the working span register
// before its first word is registered on the outputs. Throughput: one word per cycle,
// ceil((aligned start mod 4 + count * bytes per pixel) / 4) words per span, at most 48; a span
// that waits in the queue follows with no gap, else the emitter first passes its idle state.
// A two-entry queue sets busy; results cannot be stalled. Reset is synchronous, active low,
// empties the queue and the emitter and sets the pixel depth to 32 bpp.
module pixel_span_fill #(
    parameter int MAX_SPAN = psf_pkg::SPAN_LIMIT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_wdata,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [psf_pkg::ADDR_W-1:0]    i_start_address,
    input  logic [psf_pkg::COUNT_W-1:0]   i_pixel_count,
    input  logic [psf_pkg::DATA_W-1:0]    i_fill_color,
    output logic                          o_write_strobe,
    output logic [psf_pkg::WADDR_W-1:0]   o_word_address,
    output logic [psf_pkg::DATA_W-1:0]    o_write_data,
    output logic [psf_pkg::LANES-1:0]     o_byte_enable,
    output logic                          o_last_write
);

    logic               push;
    logic               pop;
    logic               queue_full;
    logic               queue_valid;
    psf_pkg::t_span_cmd front_cmd;
    psf_pkg::t_span_cmd queue_cmd;

    // Request classification and pixel depth register.
    psf_front #(
        .MAX_SPAN (MAX_SPAN)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_start         (i_start),
        .i_queue_full    (queue_full),
        .i_start_address (i_start_address),
        .i_pixel_count   (i_pixel_count),
        .i_fill_color    (i_fill_color),
        .o_busy          (o_busy),
        .o_push          (push),
        .o_cmd           (front_cmd)
    );

    // Decoupling queue.
    psf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_valid (queue_valid),
        .o_full  (queue_full)
    );

    // Word write emission.
    psf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (queue_valid),
        .i_cmd          (queue_cmd),
        .o_pop          (pop),
        .o_write_strobe (o_write_strobe),
        .o_word_address (o_word_address),
        .o_write_data   (o_write_data),
        .o_byte_enable  (o_byte_enable),
        .o_last_write   (o_last_write)
    );

endmodule

// File: verif/pixel_span_fill_tb.sv
// Self-checking testbench for pixel_span_fill: spans are driven, word writes are
// predicted and compared. Depends on rtl/psf_pkg.sv and rtl/pixel_span_fill.sv.
`timescale 1ns / 100ps

module pixel_span_fill_tb;

    localparam int SPAN_MAX     = psf_pkg::SPAN_LIMIT;
    localparam int SETTLE       = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RAND_PER_SET = 55;
    localparam int PHASES       = 8;

    // One span request as it is presented on the input ports.
    typedef struct {
        logic [psf_pkg::ADDR_W-1:0]  addr;
        logic [psf_pkg::COUNT_W-1:0] count;
        logic [psf_pkg::DATA_W-1:0]  color;
    } t_span_req;

    // One word write as it is expected on the output ports.
    typedef struct {
        logic [psf_pkg::WADDR_W-1:0] word_addr;
        logic [psf_pkg::DATA_W-1:0]  data;
        logic [psf_pkg::LANES-1:0]   be;
        logic                        last;
    } t_word_write;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_we = 1'b0;
    logic [1:0]                  i_cfg_wdata = 2'd0;
    logic                        i_start = 1'b0;
    logic                        o_busy;
    logic [psf_pkg::ADDR_W-1:0]  i_start_address = '0;
    logic [psf_pkg::COUNT_W-1:0] i_pixel_count = '0;
    logic [psf_pkg::DATA_W-1:0]  i_fill_color = '0;
    logic                        o_write_strobe;
    logic [psf_pkg::WADDR_W-1:0] o_word_address;
    logic [psf_pkg::DATA_W-1:0]  o_write_data;
    logic [psf_pkg::LANES-1:0]   o_byte_enable;
    logic                        o_last_write;

    t_span_req       spans_pending[$];
    t_word_write     writes_due[$];
    psf_pkg::t_depth depth_model = psf_pkg::DEPTH_RESET;
    int              sender_idle_pct = 0;
    int              spans_launched = 0;
    int              spans_taken = 0;
    int              writes_seen = 0;
    int              mismatch_cnt = 0;
    int              cycle_cnt = 0;

    // Pixel depth for each phase; the first phase runs at the reset depth with no write.
    psf_pkg::t_depth depth_plan [PHASES] = '{
        psf_pkg::DEPTH_32BPP, psf_pkg::DEPTH_8BPP, psf_pkg::DEPTH_16BPP, psf_pkg::DEPTH_24BPP,
        psf_pkg::DEPTH_32BPP, psf_pkg::DEPTH_24BPP, psf_pkg::DEPTH_8BPP, psf_pkg::DEPTH_16BPP};

    pixel_span_fill dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_start_address (i_start_address),
        .i_pixel_count   (i_pixel_count),
        .i_fill_color    (i_fill_color),
        .o_write_strobe  (o_write_strobe),
        .o_word_address  (o_word_address),
        .o_write_data    (o_write_data),
        .o_byte_enable   (o_byte_enable),
        .o_last_write    (o_last_write)
    );

    always #2 i_clk = ~i_clk;

    // Expand one span into the word writes it must produce at the given depth.
    task automatic predict_span_writes(input psf_pkg::t_depth depth,
                                       input logic [psf_pkg::ADDR_W-1:0] addr,
                                       input logic [psf_pkg::COUNT_W-1:0] count_in,
                                       input logic [psf_pkg::DATA_W-1:0] color);
        int unsigned bpp, pixels, nbytes, lead, nwords, w, lane, pos, k;
        logic [psf_pkg::ADDR_W-1:0] base;
        t_word_write wr;
        bpp = 32'(depth) + 32'd1;
        pixels = (32'(count_in) > SPAN_MAX) ? SPAN_MAX : 32'(count_in);
        base = addr;
        // 16- and 32-bit pixels are taken as aligned to their own size.
        if (depth == psf_pkg::DEPTH_16BPP)
            base[0] = 1'b0;
        else if (depth == psf_pkg::DEPTH_32BPP)
            base[1:0] = 2'b00;
        nbytes = pixels * bpp;
        lead = 32'(base[1:0]);
        nwords = (pixels == 0) ? 0 : (lead + nbytes + 3) / 4;
        for (w = 0; w < nwords; w++) begin
            wr.word_addr = psf_pkg::WADDR_W'(base[psf_pkg::ADDR_W-1:2] + w);
            wr.data = '0;
            wr.be = '0;
            for (lane = 0; lane < psf_pkg::LANES; lane++) begin
                pos = w * 4 + lane;
                if (pos >= lead && pos - lead < nbytes) begin
                    k = (pos - lead) % bpp;
                    wr.data[8*lane +: 8] = color[8*k +: 8];
                    wr.be[lane] = 1'b1;
                end
            end
            wr.last = (w + 1 == nwords);
            writes_due.push_back(wr);
        end
    endtask

    task automatic note_mismatch(input string what, input t_word_write want);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%0t: %s: got word %h data %h be %b last %b, %s %h data %h be %b last %b",
                     $realtime, what, o_word_address, o_write_data, o_byte_enable,
                     o_last_write, "expected word", want.word_addr, want.data, want.be,
                     want.last);
    endtask

    task automatic add_span(input logic [psf_pkg::ADDR_W-1:0] addr,
                            input logic [psf_pkg::COUNT_W-1:0] count,
                            input logic [psf_pkg::DATA_W-1:0] color);
        t_span_req req;
        req.addr = addr;
        req.count = count;
        req.color = color;
        spans_pending.push_back(req);
    endtask

    // Block until every span is taken, every write has arrived and the block has settled.
    task automatic wait_drained();
        while (spans_pending.size() != 0 || spans_launched != spans_taken ||
               writes_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Driver: launches the next span once the previous transaction has been taken.
    always @(negedge i_clk) begin
        t_span_req req;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (spans_launched == spans_taken) begin
            if (spans_pending.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                req = spans_pending.pop_front();
                i_start_address <= req.addr;
                i_pixel_count <= req.count;
                i_fill_color <= req.color;
                i_start <= 1'b1;
                spans_launched++;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // Monitor: checks each write against the oldest expectation, then records new transactions.
    always @(posedge i_clk) begin
        t_word_write want;
        if (!i_rst_n) begin
            depth_model <= psf_pkg::DEPTH_RESET;
        end else begin
            if (o_write_strobe) begin
                writes_seen++;
                if (writes_due.size() == 0) begin
                    want = '{default: '0};
                    note_mismatch("unexpected write", want);
                end else begin
                    want = writes_due.pop_front();
                    if (o_word_address !== want.word_addr || o_write_data !== want.data ||
                        o_byte_enable !== want.be || o_last_write !== want.last)
                        note_mismatch("write mismatch", want);
                end
            end
            if (i_start && !o_busy) begin
                predict_span_writes(depth_model, i_start_address, i_pixel_count, i_fill_color);
                spans_taken++;
            end
            if (i_cfg_we)
                depth_model <= psf_pkg::t_depth'(i_cfg_wdata);
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Stimulus: one depth setting per phase, directed corners in the first four, then random spans.
    initial begin
        logic [psf_pkg::ADDR_W-1:0]  addr;
        logic [psf_pkg::COUNT_W-1:0] count;
        int                          pick;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            // Phases cycle through three sender idle rates; the first has none at all.
            case (ph % 3)
                0:       sender_idle_pct = 0;
                1:       sender_idle_pct = 61;
                default: sender_idle_pct = 19;
            endcase
            if (ph != 0) begin
                @(negedge i_clk);
                i_cfg_we <= 1'b1;
                i_cfg_wdata <= depth_plan[ph];
                @(negedge i_clk);
                i_cfg_we <= 1'b0;
            end

            // Corners: zero count, full span, saturated count with address wrap, every lead.
            if (ph < 4) begin
                add_span(32'h1234_5677, 6'd0, 32'hDEAD_BEEF);
                add_span(32'h0000_0000, 6'd48, 32'h0000_0000);
                add_span(32'hFFFF_FFFD, 6'd63, 32'hFFFF_FFFF);
                add_span(32'h0000_1001, 6'd5, 32'hA5C3_1E87);
                add_span(32'h0000_2002, 6'd3, 32'h5A3C_E178);
                add_span(32'h0000_3003, 6'd1, 32'h0102_0304);
            end

            for (int n = 0; n < RAND_PER_SET; n++) begin
                addr = $urandom;
                if ($urandom_range(15) == 0)
                    addr[psf_pkg::ADDR_W-1:8] = '1;
                pick = int'($urandom_range(99));
                if (pick < 8)
                    count = 6'd0;
                else if (pick < 16)
                    count = 6'($urandom_range(63, 49));
                else if (pick < 24)
                    count = 6'd48;
                else
                    count = 6'($urandom_range(48, 1));
                add_span(addr, count, $urandom);
            end
            wait_drained();
        end

        $display("Ran %0d spans over all four pixel depths and three sender idle rates,",
                 spans_taken);
        $display("checking %0d word writes; %0d mismatches.", writes_seen, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: filelist.f
rtl/psf_pkg.sv
rtl/psf_queue.sv
rtl/psf_front.sv
rtl/psf_back.sv
rtl/pixel_span_fill.sv
verif/pixel_span_fill_tb.sv
